// ----- hdl/mhpq_pkg.sv -----
`timescale 1ns / 1ps
package mhpq_pkg;

  typedef enum logic [1:0] {
    FUNC_PUSH    = 2'd0,
    FUNC_POP     = 2'd1,
    FUNC_REPLACE = 2'd2,
    FUNC_PUSHPOP = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_t;

  typedef enum logic [1:0] {
    CELL_HOLD    = 2'd0,
    CELL_INSERT  = 2'd1,
    CELL_REMOVE  = 2'd2,
    CELL_REPLACE = 2'd3
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
  } cell_ctl_t;

endpackage

// ----- hdl/min_heap_priority_queue.sv -----
`timescale 1ns / 1ps
// Priority queue of signed keys with min-heap semantics, held as a sorted
// row of DEPTH cells with the minimum in the first cell. A command is taken
// when start is high and busy is low; its result appears on out_key,
// has_key, status and fill_count, marked by done, which is high for one
// cycle. The receiver cannot stall, so sample the result when done is
// high. First the command word is registered; then each cell, in
// parallel, moves data to or from its neighbor, comparing its entry with
// the key on insert and replace. Busy is high while the cells execute, so
// no new command is taken then, but one can be taken in the same cycle
// that the previous result is shown.
module min_heap_priority_queue #(
  parameter int DEPTH     = 64,
  parameter int KEY_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  mhpq_pkg::func_t               func,
  input  logic signed [KEY_WIDTH-1:0]   key,
  output logic                          done,
  output logic signed [KEY_WIDTH-1:0]   out_key,
  output logic                          has_key,
  output mhpq_pkg::status_t             status,
  output logic [$clog2(DEPTH+1)-1:0]    fill_count
);
  import mhpq_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);

  state_t                      state;
  state_t                      state_next;
  func_t                       cmd_func;
  logic signed [KEY_WIDTH-1:0] cmd_key;
  logic [CW-1:0]               count;
  logic [CW-1:0]               count_next;

  cell_ctl_t                   ctl;
  logic signed [KEY_WIDTH-1:0] res_key;
  logic                        res_has;
  status_t                     res_status;

  logic signed [KEY_WIDTH-1:0] q   [DEPTH];
  logic signed [KEY_WIDTH-1:0] cur [DEPTH];
  logic                        gt  [DEPTH];
  logic                        occ [DEPTH];

  assign busy = (state == ST_EXEC);

  always_comb begin
    unique case (state)
      ST_IDLE: state_next = start ? ST_EXEC : ST_IDLE;
      ST_EXEC: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl.op     = CELL_HOLD;
    res_key    = '0;
    res_has    = 1'b0;
    res_status = STATUS_OK;
    count_next = count;
    if (state == ST_EXEC) begin
      unique case (cmd_func)
        FUNC_PUSH: begin
          if (count == CW'(DEPTH)) begin
            res_status = STATUS_FULL;
          end else begin
            ctl.op     = CELL_INSERT;
            count_next = count + CW'(1);
          end
        end
        FUNC_POP: begin
          if (count == '0) begin
            res_status = STATUS_EMPTY;
          end else begin
            ctl.op     = CELL_REMOVE;
            res_key    = q[0];
            res_has    = 1'b1;
            count_next = count - CW'(1);
          end
        end
        FUNC_REPLACE: begin
          if (count == '0) begin
            res_status = STATUS_EMPTY;
          end else begin
            ctl.op  = CELL_REPLACE;
            res_key = q[0];
            res_has = 1'b1;
          end
        end
        FUNC_PUSHPOP: begin
          res_has = 1'b1;
          if (count == '0 || cmd_key <= q[0]) begin
            res_key = cmd_key;
          end else begin
            ctl.op  = CELL_REPLACE;
            res_key = q[0];
          end
        end
        default: begin
          ctl.op = CELL_HOLD;
        end
      endcase
    end
  end

  genvar i;
  generate
    for (i = 0; i < DEPTH; i++) begin : g_cell
      assign occ[i] = (CW'(i) < count);

      if (i == 0 && DEPTH > 1) begin : g_first
        mhpq_cell #(.KEY_WIDTH(KEY_WIDTH)) u_cell (
          .clk       (clk),
          .ctl       (ctl),
          .key       (cmd_key),
          .occ       (occ[i]),
          .right_occ (occ[i+1]),
          .right_key (q[i+1]),
          .left_cur  ('0),
          .left_gt   (1'b0),
          .q         (q[i]),
          .cur       (cur[i]),
          .gt        (gt[i])
        );
      end else if (i == DEPTH - 1) begin : g_last
        mhpq_cell #(.KEY_WIDTH(KEY_WIDTH)) u_cell (
          .clk       (clk),
          .ctl       (ctl),
          .key       (cmd_key),
          .occ       (occ[i]),
          .right_occ (1'b0),
          .right_key ('0),
          .left_cur  (cur[i-1]),
          .left_gt   (gt[i-1]),
          .q         (q[i]),
          .cur       (cur[i]),
          .gt        (gt[i])
        );
      end else begin : g_mid
        mhpq_cell #(.KEY_WIDTH(KEY_WIDTH)) u_cell (
          .clk       (clk),
          .ctl       (ctl),
          .key       (cmd_key),
          .occ       (occ[i]),
          .right_occ (occ[i+1]),
          .right_key (q[i+1]),
          .left_cur  (cur[i-1]),
          .left_gt   (gt[i-1]),
          .q         (q[i]),
          .cur       (cur[i]),
          .gt        (gt[i])
        );
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      done  <= (state == ST_EXEC);
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && start) begin
      cmd_func <= func;
      cmd_key  <= key;
    end
    if (state == ST_EXEC) begin
      out_key    <= res_key;
      has_key    <= res_has;
      status     <= res_status;
      fill_count <= count_next;
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("entry count exceeds depth");

  a_done_after_exec: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == ST_EXEC))
    else $error("result strobe without an executed command");

  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EXEC && cmd_func == FUNC_PUSH && count != CW'(DEPTH))
      |=> (count == $past(count) + CW'(1)))
    else $error("accepted push did not grow the queue");

  a_no_key_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !has_key) |-> (out_key == '0))
    else $error("returned key not cleared when absent");
`endif

endmodule

// ----- hdl/mhpq_cell.sv -----
`timescale 1ns / 1ps
module mhpq_cell #(
  parameter int KEY_WIDTH = 32
) (
  input  logic                        clk,
  input  mhpq_pkg::cell_ctl_t         ctl,
  input  logic signed [KEY_WIDTH-1:0] key,
  input  logic                        occ,
  input  logic                        right_occ,
  input  logic signed [KEY_WIDTH-1:0] right_key,
  input  logic signed [KEY_WIDTH-1:0] left_cur,
  input  logic                        left_gt,
  output logic signed [KEY_WIDTH-1:0] q,
  output logic signed [KEY_WIDTH-1:0] cur,
  output logic                        gt
);
  import mhpq_pkg::*;

  logic signed [KEY_WIDTH-1:0] q_next;
  logic                        shift;
  logic                        cur_occ;

  // Removing the head shifts the whole row left by one, so the cell looks
  // at its right neighbor's word instead of its own.
  assign shift   = (ctl.op == CELL_REMOVE) || (ctl.op == CELL_REPLACE);
  assign cur     = shift ? right_key : q;
  assign cur_occ = shift ? right_occ : occ;
  assign gt      = !cur_occ || (cur > key);

  always_comb begin
    unique case (ctl.op)
      CELL_HOLD:   q_next = q;
      CELL_REMOVE: q_next = right_key;
      CELL_INSERT, CELL_REPLACE: begin
        if (gt) begin
          q_next = left_gt ? left_cur : key;
        end else begin
          q_next = cur;
        end
      end
      default:     q_next = q;
    endcase
  end

  always_ff @(posedge clk) begin
    q <= q_next;
  end

endmodule
